FILE: src/clock_offset_tracker_assert.svh
// Assertion macros for the clock offset tracker.
// Expects signals named clk and rst in the scope where a macro is used.
`ifndef CLOCK_OFFSET_TRACKER_ASSERT_SVH
`define CLOCK_OFFSET_TRACKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/cot_pkg.sv
// Package for the clock offset tracker: item types, command, status and
// register index codes, and register reset values. No dependencies.
`default_nettype none

package cot_pkg;

  localparam logic [1:0] CMD_REQUEST  = 2'd0;
  localparam logic [1:0] CMD_RESPONSE = 2'd1;
  localparam logic [1:0] CMD_REBASE   = 2'd2;
  localparam logic [1:0] CMD_RESET    = 2'd3;

  localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
  localparam logic [2:0] STATUS_SLEWED   = 3'd1;
  localparam logic [2:0] STATUS_JUMPED   = 3'd2;
  localparam logic [2:0] STATUS_UNKNOWN  = 3'd3;
  localparam logic [2:0] STATUS_RECORDED = 3'd4;
  localparam logic [2:0] STATUS_FALLBACK = 3'd5;

  localparam logic [1:0] CFG_STALE_AFTER = 2'd0;
  localparam logic [1:0] CFG_SLEW_BAND   = 2'd1;
  localparam logic [1:0] CFG_MAX_SLEW    = 2'd2;

  localparam logic [31:0] STALE_AFTER_RESET = 32'd5000;
  localparam logic [30:0] SLEW_BAND_RESET   = 31'd100;
  localparam logic [30:0] MAX_SLEW_RESET    = 31'd5;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] tag;
    logic [31:0] remote_value;
    logic [31:0] local_now;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_time;
    logic        is_fresh;
    logic [31:0] offset_out;
    logic [31:0] round_trip_out;
  } out_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] sent;
  } entry_t;

endpackage

`default_nettype wire

FILE: src/clock_offset_tracker.sv
// Clock offset tracker: top level with the request window memory and the
// shared 32-bit add/subtract unit under one sequencer. Depends on cot_pkg.
//
// The block takes one item at a time. A request item passes through the
// window write, an age check and the final step; a rebase through the age
// check, the rebase subtraction when the estimate is fresh, and the final
// step; a reset item goes straight to the final step. A response item
// searches the window of outstanding requests through the single read port
// of the window memory, one entry per cycle, and then runs up to seven steps
// of the shared 32-bit adder. The window is a circular buffer, so old
// entries are dropped by advancing the head pointer. There is no clearing
// pass after reset. A finished result waits in the output register while the
// next item is accepted; if the previous result has still not been taken,
// the sequencer holds in its final step.
`default_nettype none

module clock_offset_tracker #(
  parameter int WINDOW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire cot_pkg::in_t   item,
  output logic                result_valid,
  input  wire logic           result_ready,
  output cot_pkg::out_t       result,
  input  wire logic           cfg_we,
  input  wire logic [1:0]     cfg_index,
  input  wire logic [31:0]    cfg_data
);

  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW = $clog2(WINDOW + 1);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_REQ  = 4'd1;
  localparam logic [3:0] ST_SRCH = 4'd2;
  localparam logic [3:0] ST_RTT  = 4'd3;
  localparam logic [3:0] ST_MID  = 4'd4;
  localparam logic [3:0] ST_SMP  = 4'd5;
  localparam logic [3:0] ST_AGE  = 4'd6;
  localparam logic [3:0] ST_DIF  = 4'd7;
  localparam logic [3:0] ST_ABS  = 4'd8;
  localparam logic [3:0] ST_DEC  = 4'd9;
  localparam logic [3:0] ST_SLEW = 4'd10;
  localparam logic [3:0] ST_REB  = 4'd11;
  localparam logic [3:0] ST_FIN  = 4'd12;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(WINDOW - 1)) ? '0 : p + AW'(1);
  endfunction

  logic [3:0]  state;
  logic [31:0] stale_after;
  logic [30:0] slew_band;
  logic [30:0] max_slew;

  logic        have_offset;
  logic [31:0] offset;
  logic [31:0] round_trip;
  logic [31:0] last_sample_time;
  logic [CW-1:0] count;
  logic [AW-1:0] head;
  logic [AW-1:0] tail;

  logic [AW-1:0] srch_addr;
  logic [CW-1:0] issued;
  logic          rd_vld;
  logic [AW-1:0] cmp_addr;
  logic [CW-1:0] cmp_pos;

  cot_pkg::entry_t mem [WINDOW];
  cot_pkg::entry_t rd_data;
  logic            rd_en;

  cot_pkg::in_t cur;
  logic [31:0] sent;
  logic [31:0] rtt;
  logic [31:0] mid;
  logic [31:0] sample;
  logic [31:0] diff;
  logic [31:0] absd;
  logic [31:0] res_time;
  logic [2:0]  status;
  logic        fresh;
  logic        hit;

  logic [31:0] add_a;
  logic [31:0] add_b;
  logic        add_sub;
  logic [31:0] add_res;

  logic item_acc;
  logic hit_now;
  logic fin_go;
  logic clamp;

  assign item_ready = (state == ST_IDLE) && !rst;
  assign item_acc   = item_valid && item_ready;
  assign hit_now    = (state == ST_SRCH) && rd_vld && (rd_data.tag == cur.tag);
  assign fin_go     = (state == ST_FIN) && (!result_valid || result_ready);
  assign rd_en      = (state == ST_SRCH) && !hit_now && (issued < count);
  assign clamp      = absd > {1'b0, max_slew};

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state)
      ST_RTT: begin
        add_a   = cur.local_now;
        add_b   = sent;
        add_sub = 1'b1;
      end
      ST_MID: begin
        add_a = sent;
        add_b = {1'b0, rtt[31:1]};
      end
      ST_SMP: begin
        add_a   = cur.remote_value;
        add_b   = mid;
        add_sub = 1'b1;
      end
      ST_AGE: begin
        add_a   = cur.local_now;
        add_b   = last_sample_time;
        add_sub = 1'b1;
      end
      ST_DIF: begin
        add_a   = sample;
        add_b   = offset;
        add_sub = 1'b1;
      end
      ST_ABS: begin
        add_a   = diff[31] ? '0 : diff;
        add_b   = diff[31] ? diff : '0;
        add_sub = 1'b1;
      end
      ST_SLEW: begin
        add_a   = offset;
        add_b   = clamp ? {1'b0, max_slew} : diff;
        add_sub = clamp && diff[31];
      end
      ST_REB: begin
        add_a   = cur.remote_value;
        add_b   = offset;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
      end
    endcase
  end

  assign add_res = add_sub ? (add_a - add_b) : (add_a + add_b);

  always_ff @(posedge clk) begin
    if (state == ST_REQ) begin
      mem[tail] <= '{tag: cur.tag, sent: cur.local_now};
    end
    if (rd_en) begin
      rd_data <= mem[srch_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_after <= cot_pkg::STALE_AFTER_RESET;
      slew_band   <= cot_pkg::SLEW_BAND_RESET;
      max_slew    <= cot_pkg::MAX_SLEW_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cot_pkg::CFG_STALE_AFTER: stale_after <= cfg_data;
        cot_pkg::CFG_SLEW_BAND:   slew_band   <= cfg_data[30:0];
        cot_pkg::CFG_MAX_SLEW:    max_slew    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      have_offset      <= 1'b0;
      offset           <= '0;
      round_trip       <= '0;
      last_sample_time <= '0;
      count            <= '0;
      head             <= '0;
      tail             <= '0;
      srch_addr        <= '0;
      issued           <= '0;
      rd_vld           <= 1'b0;
      cmp_addr         <= '0;
      cmp_pos          <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (fin_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_acc) begin
            unique case (item.command)
              cot_pkg::CMD_REQUEST:  state <= ST_REQ;
              cot_pkg::CMD_RESPONSE: begin
                state     <= ST_SRCH;
                srch_addr <= head;
                issued    <= '0;
                rd_vld    <= 1'b0;
              end
              cot_pkg::CMD_REBASE:   state <= ST_AGE;
              default: begin
                state            <= ST_FIN;
                have_offset      <= 1'b0;
                offset           <= '0;
                round_trip       <= '0;
                last_sample_time <= '0;
                count            <= '0;
                head             <= '0;
                tail             <= '0;
              end
            endcase
          end
        end
        ST_REQ: begin
          tail <= ptr_inc(tail);
          if (count == CW'(WINDOW)) begin
            head <= ptr_inc(head);
          end else begin
            count <= count + CW'(1);
          end
          state <= ST_AGE;
        end
        ST_SRCH: begin
          rd_vld <= rd_en;
          if (hit_now) begin
            head  <= ptr_inc(cmp_addr);
            count <= count - cmp_pos - CW'(1);
            state <= ST_RTT;
          end else if (rd_en) begin
            cmp_addr  <= srch_addr;
            cmp_pos   <= issued;
            srch_addr <= ptr_inc(srch_addr);
            issued    <= issued + CW'(1);
          end else begin
            state <= ST_AGE;
          end
        end
        ST_RTT:  state <= ST_MID;
        ST_MID:  state <= ST_SMP;
        ST_SMP:  state <= ST_AGE;
        ST_AGE: begin
          if (hit) begin
            round_trip       <= rtt;
            last_sample_time <= cur.local_now;
            if (!(have_offset && (add_res < stale_after))) begin
              offset      <= sample;
              have_offset <= 1'b1;
              state       <= ST_FIN;
            end else begin
              state <= ST_DIF;
            end
          end else if ((cur.command == cot_pkg::CMD_REBASE)
                       && have_offset && (add_res < stale_after)) begin
            state <= ST_REB;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_DIF:  state <= ST_ABS;
        ST_ABS:  state <= ST_DEC;
        ST_DEC: begin
          if (diff == '0) begin
            state <= ST_FIN;
          end else if (absd > {1'b0, slew_band}) begin
            offset <= sample;
            state  <= ST_FIN;
          end else begin
            state <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          offset <= add_res;
          state  <= ST_FIN;
        end
        ST_REB:  state <= ST_FIN;
        ST_FIN: begin
          if (fin_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          cur      <= item;
          res_time <= '0;
          hit      <= 1'b0;
          fresh    <= 1'b0;
          status   <= (item.command == cot_pkg::CMD_REQUEST) ?
                      cot_pkg::STATUS_RECORDED : cot_pkg::STATUS_ACCEPTED;
        end
      end
      ST_SRCH: begin
        if (hit_now) begin
          sent <= rd_data.sent;
          hit  <= 1'b1;
        end else if (!rd_en) begin
          status <= cot_pkg::STATUS_UNKNOWN;
        end
      end
      ST_RTT: rtt    <= add_res;
      ST_MID: mid    <= add_res;
      ST_SMP: sample <= add_res;
      ST_AGE: begin
        fresh <= have_offset && (add_res < stale_after);
        if ((cur.command == cot_pkg::CMD_REBASE)
            && !(have_offset && (add_res < stale_after))) begin
          status   <= cot_pkg::STATUS_FALLBACK;
          res_time <= cur.local_now;
        end
      end
      ST_DIF: diff <= add_res;
      ST_ABS: absd <= add_res;
      ST_DEC: begin
        if (diff == '0) begin
          status <= cot_pkg::STATUS_ACCEPTED;
        end else if (absd > {1'b0, slew_band}) begin
          status <= cot_pkg::STATUS_JUMPED;
        end else begin
          status <= cot_pkg::STATUS_SLEWED;
        end
      end
      ST_REB: res_time <= add_res;
      ST_FIN: begin
        if (fin_go) begin
          result.status         <= status;
          result.result_time    <= res_time;
          result.is_fresh       <= hit ? (stale_after != '0) : fresh;
          result.offset_out     <= offset;
          result.round_trip_out <= round_trip;
        end
      end
      default: ;
    endcase
  end

  `include "clock_offset_tracker_assert.svh"

  `COT_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(WINDOW), "pending count exceeds window")
  `COT_ASSERT_NOW(a_search_bound, state == ST_SRCH, issued <= count, "search ran past window")
  `COT_ASSERT_NEXT(a_busy_after_accept, item_acc, state != ST_IDLE, "idle after accepting item")
  `COT_ASSERT_NEXT(a_hit_shrinks, hit_now, count < $past(count), "hit did not drop entries")

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for clock_offset_tracker: a table of directed items,
// then random request, response, rebase and reset traffic under several
// register settings. Depends on cot_pkg and the clock_offset_tracker RTL.
`timescale 1ns / 1ps

module tb;

  localparam int WIN = 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 217;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    cot_pkg::in_t  stim;
    bit            known;
    cot_pkg::out_t want;
  } plan_row_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          item_valid = 1'b0;
  logic          item_ready;
  cot_pkg::in_t  item = '0;
  logic          result_valid;
  logic          result_ready = 1'b0;
  cot_pkg::out_t result;
  logic          cfg_we = 1'b0;
  logic [1:0]    cfg_index = '0;
  logic [31:0]   cfg_data = '0;

  logic [31:0] stale_lim = cot_pkg::STALE_AFTER_RESET;
  logic [30:0] band_lim = cot_pkg::SLEW_BAND_RESET;
  logic [30:0] step_lim = cot_pkg::MAX_SLEW_RESET;
  logic        have_est = 1'b0;
  logic [31:0] est_offset = '0;
  logic [31:0] est_rtt = '0;
  logic [31:0] est_stamp = '0;
  int          win_count = 0;
  logic [31:0] win_tag [WIN];
  logic [31:0] win_sent [WIN];

  cot_pkg::out_t due_results[$];
  plan_row_t     plan[$];
  int          faults = 0;
  int          checked = 0;
  int          offered = 0;
  int          hold_asks = 0;
  bit          calm = 1'b0;
  int          seen [8];
  logic [31:0] wall = '0;
  logic [31:0] tag_seq = '0;
  int          burst = 0;

  clock_offset_tracker #(.WINDOW(WIN)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", due_results.size());
    $display("status: fail");
    $finish;
  end

  function automatic logic fresh_at(input logic [31:0] at_ms);
    logic [31:0] age;
    age = at_ms - est_stamp;
    return have_est && (age < stale_lim);
  endfunction

  function automatic cot_pkg::out_t advance_tracker(input cot_pkg::in_t x);
    cot_pkg::out_t r;
    int          hit;
    int          keep;
    logic        was_fresh;
    logic [31:0] sent;
    logic [31:0] span;
    logic [31:0] smp;
    logic [31:0] dif;
    longint      sd;
    longint      mv;
    r = '0;
    case (x.command)
      cot_pkg::CMD_REQUEST: begin
        if (win_count == WIN) begin
          for (int i = 1; i < WIN; i++) begin
            win_tag[i - 1] = win_tag[i];
            win_sent[i - 1] = win_sent[i];
          end
          win_count = WIN - 1;
        end
        win_tag[win_count] = x.tag;
        win_sent[win_count] = x.local_now;
        win_count++;
        r.status = cot_pkg::STATUS_RECORDED;
      end
      cot_pkg::CMD_RESPONSE: begin
        hit = -1;
        for (int i = 0; i < win_count; i++) begin
          if (hit < 0 && win_tag[i] == x.tag) hit = i;
        end
        if (hit < 0) begin
          r.status = cot_pkg::STATUS_UNKNOWN;
        end else begin
          sent = win_sent[hit];
          keep = win_count - hit - 1;
          for (int i = 0; i < keep; i++) begin
            win_tag[i] = win_tag[hit + 1 + i];
            win_sent[i] = win_sent[hit + 1 + i];
          end
          win_count = keep;
          span = x.local_now - sent;
          smp = x.remote_value - (sent + (span >> 1));
          was_fresh = fresh_at(x.local_now);
          est_rtt = span;
          est_stamp = x.local_now;
          if (!was_fresh) begin
            est_offset = smp;
            have_est = 1'b1;
            r.status = cot_pkg::STATUS_ACCEPTED;
          end else begin
            dif = smp - est_offset;
            sd = longint'($signed(dif));
            if (sd == 0) begin
              r.status = cot_pkg::STATUS_ACCEPTED;
            end else if (sd > longint'(band_lim) || sd < -longint'(band_lim)) begin
              est_offset = smp;
              r.status = cot_pkg::STATUS_JUMPED;
            end else begin
              mv = sd;
              if (mv > longint'(step_lim)) mv = longint'(step_lim);
              else if (mv < -longint'(step_lim)) mv = -longint'(step_lim);
              est_offset = est_offset + mv[31:0];
              r.status = cot_pkg::STATUS_SLEWED;
            end
          end
        end
      end
      cot_pkg::CMD_REBASE: begin
        if (fresh_at(x.local_now)) begin
          r.status = cot_pkg::STATUS_ACCEPTED;
          r.result_time = x.remote_value - est_offset;
        end else begin
          r.status = cot_pkg::STATUS_FALLBACK;
          r.result_time = x.local_now;
        end
      end
      default: begin
        have_est = 1'b0;
        est_offset = '0;
        est_rtt = '0;
        est_stamp = '0;
        win_count = 0;
        r.status = cot_pkg::STATUS_ACCEPTED;
      end
    endcase
    r.is_fresh = fresh_at(x.local_now);
    r.offset_out = est_offset;
    r.round_trip_out = est_rtt;
    seen[r.status]++;
    return r;
  endfunction

  function automatic plan_row_t step_row(input logic [1:0] c, input logic [31:0] t,
                                         input logic [31:0] rv, input logic [31:0] n);
    plan_row_t row;
    row.stim = '{command: c, tag: t, remote_value: rv, local_now: n};
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  function automatic plan_row_t known_row(input logic [1:0] c, input logic [31:0] t,
                                          input logic [31:0] rv, input logic [31:0] n,
                                          input logic [2:0] s, input logic [31:0] rt,
                                          input logic f, input logic [31:0] o,
                                          input logic [31:0] trip);
    plan_row_t row;
    row = step_row(c, t, rv, n);
    row.known = 1'b1;
    row.want = '{status: s, result_time: rt, is_fresh: f, offset_out: o,
                 round_trip_out: trip};
    return row;
  endfunction

  task automatic offer(input cot_pkg::in_t x, input bit known, input cot_pkg::out_t want);
    cot_pkg::out_t got;
    item_valid <= 1'b1;
    item <= x;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    got = advance_tracker(x);
    due_results.push_back(known ? want : got);
    offered++;
  endtask

  task automatic idle_gap();
    while (!calm && $urandom_range(99) < 21) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      cot_pkg::CFG_STALE_AFTER: stale_lim = val;
      cot_pkg::CFG_SLEW_BAND:   band_lim = val[30:0];
      cot_pkg::CFG_MAX_SLEW:    step_lim = val[30:0];
      default: ;
    endcase
  endtask

  task automatic pick_item(output cot_pkg::in_t x);
    int          roll;
    int          idx;
    int          lim;
    int          pick;
    logic [31:0] sent;
    logic [31:0] base;
    logic [31:0] delta;
    x.command = cot_pkg::CMD_REQUEST;
    x.tag = $urandom;
    x.remote_value = $urandom;
    if ($urandom_range(99) < 3) wall = wall + $urandom_range(200000, 1000);
    else wall = wall + $urandom_range(25, 0);
    x.local_now = wall;
    if (burst == 0 && $urandom_range(99) < 4) burst = $urandom_range(12, 6);
    roll = (burst > 0) ? 0 : $urandom_range(99);
    if (burst > 0) burst--;
    if (roll < 36) begin
      x.tag = (win_count > 0 && $urandom_range(19) == 0) ? win_tag[win_count - 1] : tag_seq;
      tag_seq = tag_seq + 1;
    end else if (roll < 72) begin
      x.command = cot_pkg::CMD_RESPONSE;
      if (win_count > 0) begin
        pick = $urandom_range(9);
        idx = (pick < 5) ? win_count - 1 : (pick < 8) ? 0 : $urandom_range(win_count - 1);
        x.tag = win_tag[idx];
        sent = win_sent[idx];
        base = sent + ((wall - sent) >> 1) + est_offset;
        lim = (band_lim < 64) ? int'(band_lim) : 64;
        delta = $urandom_range(lim);
        pick = $urandom_range(9);
        if (pick >= 6 && pick < 8) delta = {1'b0, band_lim} + 32'd1 + $urandom_range(500);
        if (pick < 2) x.remote_value = base;
        else if (pick < 9) x.remote_value = $urandom_range(1) ? base + delta : base - delta;
      end
    end else if (roll < 84) begin
      x.command = cot_pkg::CMD_REBASE;
      if ($urandom_range(3) != 0) x.remote_value = wall + est_offset + $urandom_range(1000);
    end else if (roll < 99) begin
      x.command = (roll < 92) ? cot_pkg::CMD_RESPONSE : 2'($urandom_range(2));
    end else begin
      x.command = cot_pkg::CMD_RESET;
    end
  endtask

  initial begin
    cot_pkg::out_t want;
    int   hold_left;
    int   holds_done;
    hold_left = 0;
    holds_done = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (result_valid && result_ready) begin
        checked++;
        if (due_results.size() == 0) begin
          faults++;
          if (faults <= 10) $display("unexpected result: status %0d time %h offset %h",
                                     result.status, result.result_time, result.offset_out);
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status || result.result_time !== want.result_time ||
              result.is_fresh !== want.is_fresh || result.offset_out !== want.offset_out ||
              result.round_trip_out !== want.round_trip_out) begin
            faults++;
            if (faults <= 10)
              $display("result %0d differs: want %0d %h %b %h %h, got %0d %h %b %h %h",
                       checked, want.status, want.result_time, want.is_fresh,
                       want.offset_out, want.round_trip_out, result.status,
                       result.result_time, result.is_fresh, result.offset_out,
                       result.round_trip_out);
          end
        end
      end
      if (holds_done != hold_asks) begin
        holds_done = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= calm || ($urandom_range(99) >= 21);
      end
      @(posedge clk);
    end
  end

  initial begin
    cot_pkg::in_t x;
    logic [31:0] fill_tags [9];
    logic [31:0] ph_stale [PHASES];
    logic [31:0] ph_band [PHASES];
    logic [31:0] ph_step [PHASES];
    fill_tags = '{32'd20, 32'd9, 32'd9, 32'd21, 32'd22, 32'd23, 32'd24, 32'd25, 32'd26};
    ph_stale = '{cot_pkg::STALE_AFTER_RESET, 32'd0, 32'hFFFF_FFFF, 32'd300, 32'hFFFF_FFFF,
                 $urandom_range(20000, 50)};
    ph_band = '{32'(cot_pkg::SLEW_BAND_RESET), 32'h7FFF_FFFF, 32'd0, 32'd20, 32'hFFFF_FFFF,
                {1'($urandom_range(1)), 31'($urandom_range(300))}};
    ph_step = '{32'(cot_pkg::MAX_SLEW_RESET), 32'd0, 32'h7FFF_FFFF, 32'd3, 32'h8000_0007,
                $urandom_range(50)};

    plan.push_back(known_row(cot_pkg::CMD_REBASE, 0, 1234, 1000,
                             cot_pkg::STATUS_FALLBACK, 1000, 0, 0, 0));
    plan.push_back(known_row(cot_pkg::CMD_RESPONSE, 0, 0, 0,
                             cot_pkg::STATUS_UNKNOWN, 0, 0, 0, 0));
    plan.push_back(known_row(cot_pkg::CMD_REQUEST, 1, 0, 1000,
                             cot_pkg::STATUS_RECORDED, 0, 0, 0, 0));
    plan.push_back(known_row(cot_pkg::CMD_RESPONSE, 1, 5000, 1010,
                             cot_pkg::STATUS_ACCEPTED, 0, 1, 3995, 10));
    plan.push_back(step_row(cot_pkg::CMD_REQUEST, 2, 0, 2000));
    plan.push_back(step_row(cot_pkg::CMD_RESPONSE, 2, 6013, 2020));
    plan.push_back(step_row(cot_pkg::CMD_REQUEST, 3, 0, 2100));
    plan.push_back(step_row(cot_pkg::CMD_RESPONSE, 3, 6105, 2110));
    plan.push_back(step_row(cot_pkg::CMD_REQUEST, 6, 0, 2400));
    plan.push_back(step_row(cot_pkg::CMD_RESPONSE, 6, 5400, 2400));
    plan.push_back(step_row(cot_pkg::CMD_REBASE, 0, 10000, 2500));
    foreach (fill_tags[i]) begin
      plan.push_back(step_row(cot_pkg::CMD_REQUEST, fill_tags[i], 0, 3000 + i));
    end
    plan.push_back(step_row(cot_pkg::CMD_RESPONSE, 20, 0, 3010));
    plan.push_back(step_row(cot_pkg::CMD_REBASE, 0, 1, 9000));
    plan.push_back(step_row(cot_pkg::CMD_RESPONSE, 9, 7777, 9001));
    plan.push_back(step_row(cot_pkg::CMD_RESPONSE, 9, 12000, 9100));
    plan.push_back(known_row(cot_pkg::CMD_RESET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000,
                             cot_pkg::STATUS_ACCEPTED, 0, 0, 0, 0));
    plan.push_back(known_row(cot_pkg::CMD_REQUEST, 32'hFFFF_FFFF, 0, 32'hFFFF_FFF0,
                             cot_pkg::STATUS_RECORDED, 0, 0, 0, 0));
    plan.push_back(known_row(cot_pkg::CMD_RESPONSE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h10,
                             cot_pkg::STATUS_ACCEPTED, 0, 1, 32'hFFFF_FFFF, 32'h20));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      offer(plan[i].stim, plan[i].known, plan[i].want);
      idle_gap();
    end

    tag_seq = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      item_valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clk);
      if (p > 0) begin
        if (p == 3) write_reg(CFG_UNUSED, $urandom);
        write_reg(cot_pkg::CFG_STALE_AFTER, ph_stale[p]);
        write_reg(cot_pkg::CFG_SLEW_BAND, ph_band[p]);
        write_reg(cot_pkg::CFG_MAX_SLEW, ph_step[p]);
        cfg_we <= 1'b0;
      end
      calm = (p == 3);
      if (p == 2 || p == 5) hold_asks++;
      wall = (p == 4) ? 32'hFFFF_F000 : $urandom;
      repeat (PHASE_ITEMS) begin
        pick_item(x);
        offer(x, 1'b0, '0);
        idle_gap();
      end
    end

    item_valid <= 1'b0;
    calm = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("run covered %0d items (%0d from the table) under %0d register settings",
             offered, plan.size(), PHASES);
    $display("outcomes: %0d recorded, %0d accepted, %0d slewed, %0d jumped, %0d unknown,",
             seen[cot_pkg::STATUS_RECORDED], seen[cot_pkg::STATUS_ACCEPTED],
             seen[cot_pkg::STATUS_SLEWED], seen[cot_pkg::STATUS_JUMPED],
             seen[cot_pkg::STATUS_UNKNOWN]);
    $display("          %0d fallback", seen[cot_pkg::STATUS_FALLBACK]);
    if (faults == 0 && due_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d faults, %0d results missing", faults, due_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
